>>> hdl/ppcie_pkg.sv
// ----------------------------------------------------------------------------
// ppcie_pkg
// Shared constants, opcodes and types for the immediate-form integer execute
// stage.
// ----------------------------------------------------------------------------
package ppcie_pkg;

   localparam int REG_COUNT_DEF  = 32;
   localparam int DATA_WIDTH_DEF = 64;

   localparam int INSTR_WIDTH = 32;
   localparam int IMM_WIDTH   = 16;
   localparam int IMM_SHIFT   = 16;
   localparam int GPR_IDX_W   = 5;
   localparam int CR_FIELD_W  = 3;
   localparam int CR_BITS_W   = 4;
   localparam int CR_WIDTH    = 32;

   // primary opcodes
   localparam logic [5:0] OP_MULLI  = 6'd7;
   localparam logic [5:0] OP_SUBFIC = 6'd8;
   localparam logic [5:0] OP_CMPLI  = 6'd10;
   localparam logic [5:0] OP_CMPI   = 6'd11;
   localparam logic [5:0] OP_ADDIC  = 6'd12;
   localparam logic [5:0] OP_ADDICR = 6'd13;
   localparam logic [5:0] OP_ADDI   = 6'd14;
   localparam logic [5:0] OP_ADDIS  = 6'd15;
   localparam logic [5:0] OP_ORI    = 6'd24;
   localparam logic [5:0] OP_ORIS   = 6'd25;
   localparam logic [5:0] OP_XORI   = 6'd26;
   localparam logic [5:0] OP_XORIS  = 6'd27;
   localparam logic [5:0] OP_ANDIR  = 6'd28;
   localparam logic [5:0] OP_ANDISR = 6'd29;

   // condition field nibbles, SO always clear
   localparam logic [CR_BITS_W-1:0] CR_LT = 4'b1000;
   localparam logic [CR_BITS_W-1:0] CR_GT = 4'b0100;
   localparam logic [CR_BITS_W-1:0] CR_EQ = 4'b0010;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_UNIMPL = 1'b1;

   typedef struct packed {
      logic                  status;
      logic                  reg_written;
      logic [GPR_IDX_W-1:0]  dest_index;
      logic                  carry_written;
      logic                  carry_value;
      logic                  cr_written;
      logic [CR_FIELD_W-1:0] cr_field;
      logic [CR_BITS_W-1:0]  cr_bits;
   } ppcie_ctrl_type;

endpackage

>>> hdl/ppcie_if.sv
// ----------------------------------------------------------------------------
// ppcie_if
// Valid/ready channels for instruction words and execute results.
// ----------------------------------------------------------------------------
interface ppcie_req_if;
   logic                               valid;
   logic                               ready;
   logic [ppcie_pkg::INSTR_WIDTH-1:0]  instruction;

   modport source (output valid, output instruction, input ready);
   modport sink (input valid, input instruction, output ready);
endinterface

interface ppcie_rsp_if #(
   parameter int DATA_WIDTH = ppcie_pkg::DATA_WIDTH_DEF
);
   logic                               valid;
   logic                               ready;
   logic                               status;
   logic                               reg_written;
   logic [ppcie_pkg::GPR_IDX_W-1:0]    dest_index;
   logic [DATA_WIDTH-1:0]              dest_value;
   logic                               carry_written;
   logic                               carry_value;
   logic                               cr_written;
   logic [ppcie_pkg::CR_FIELD_W-1:0]   cr_field;
   logic [ppcie_pkg::CR_BITS_W-1:0]    cr_bits;

   modport source (output valid, output status, output reg_written, output dest_index,
                   output dest_value, output carry_written, output carry_value,
                   output cr_written, output cr_field, output cr_bits, input ready);
   modport sink (input valid, input status, input reg_written, input dest_index,
                 input dest_value, input carry_written, input carry_value,
                 input cr_written, input cr_field, input cr_bits, output ready);
endinterface

>>> hdl/ppc_immediate_integer_execute.sv
// ----------------------------------------------------------------------------
// ppc_immediate_integer_execute
// Execute stage for 64-bit PowerPC D-form integer instructions with register
// file, carry bit and condition register.
// ----------------------------------------------------------------------------
//  channel    direction  handshake     payload
//  req_chan   in         valid/ready   instruction (32)
//  rsp_chan   out        valid/ready   status, reg_written, dest_index, dest_value,
//                                      carry_written, carry_value, cr_written,
//                                      cr_field, cr_bits
//
//  One instruction per cycle sustained while the result is taken; the register
//  file read and instruction capture happen at the accept edge, and the
//  execute result is registered into the output register when it advances.
//  The write-back of one instruction is bypassed to the next in the register
//  file, so dependent instructions still issue back to back.
//  A stalled result holds its output register; the execute register keeps
//  accepting until both are full. Synchronous reset clears all valid bits,
//  the register file, carry and condition register.
// ----------------------------------------------------------------------------
module ppc_immediate_integer_execute #(
   parameter int REG_COUNT  = ppcie_pkg::REG_COUNT_DEF,
   parameter int DATA_WIDTH = ppcie_pkg::DATA_WIDTH_DEF
) (
   input logic           clock,
   input logic           reset,
   ppcie_req_if.sink     req_chan,
   ppcie_rsp_if.source   rsp_chan
);

   localparam int IDX_W = $clog2(REG_COUNT);
   localparam int CR_W  = ppcie_pkg::CR_WIDTH;
   localparam int NF    = CR_W / ppcie_pkg::CR_BITS_W;

   logic                                  accept;
   logic                                  advance;
   logic                                  ex_valid_ff;
   logic                                  ex_valid_in;
   logic [ppcie_pkg::INSTR_WIDTH-1:0]     ex_ins_ff;
   logic [DATA_WIDTH-1:0]                 opnd_a;
   logic [DATA_WIDTH-1:0]                 opnd_s;
   ppcie_pkg::ppcie_ctrl_type             alu_ctrl;
   logic [DATA_WIDTH-1:0]                 alu_result;
   logic                                  out_valid_ff;
   logic                                  out_valid_in;
   ppcie_pkg::ppcie_ctrl_type             out_ctrl_ff;
   logic [DATA_WIDTH-1:0]                 out_value_ff;
   logic                                  carry_ff;
   logic                                  carry_in;
   logic [CR_W-1:0]                       cr_ff;
   logic [CR_W-1:0]                       cr_in;

   assign advance        = ex_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !ex_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   ppcie_regfile #(
      .REG_COUNT  (REG_COUNT),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (IDX_W'(req_chan.instruction[20:16])),
      .rd_addr_b (IDX_W'(req_chan.instruction[25:21])),
      .rd_data_a (opnd_a),
      .rd_data_b (opnd_s),
      .wr_en     (advance && alu_ctrl.reg_written),
      .wr_addr   (IDX_W'(alu_ctrl.dest_index)),
      .wr_data   (alu_result)
   );

   ppcie_alu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_alu (
      .instruction (ex_ins_ff),
      .opnd_a      (opnd_a),
      .opnd_s      (opnd_s),
      .ctrl        (alu_ctrl),
      .result      (alu_result)
   );

   always_comb begin
      ex_valid_in  = accept || (ex_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      carry_in     = carry_ff;
      cr_in        = cr_ff;
      if (advance && alu_ctrl.carry_written) begin
         carry_in = alu_ctrl.carry_value;
      end
      // field 0 sits in the top nibble
      for (int f = 0; f < NF; f++) begin
         if (advance && alu_ctrl.cr_written && alu_ctrl.cr_field == f) begin
            cr_in[CR_W-1-ppcie_pkg::CR_BITS_W*f -: ppcie_pkg::CR_BITS_W] = alu_ctrl.cr_bits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         carry_ff     <= 1'b0;
         cr_ff        <= '0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         out_valid_ff <= out_valid_in;
         carry_ff     <= carry_in;
         cr_ff        <= cr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_ins_ff <= req_chan.instruction;
      end
      if (advance) begin
         out_ctrl_ff  <= alu_ctrl;
         out_value_ff <= alu_result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = out_ctrl_ff.status;
   assign rsp_chan.reg_written   = out_ctrl_ff.reg_written;
   assign rsp_chan.dest_index    = out_ctrl_ff.dest_index;
   assign rsp_chan.dest_value    = out_value_ff;
   assign rsp_chan.carry_written = out_ctrl_ff.carry_written;
   assign rsp_chan.carry_value   = out_ctrl_ff.carry_value;
   assign rsp_chan.cr_written    = out_ctrl_ff.cr_written;
   assign rsp_chan.cr_field      = out_ctrl_ff.cr_field;
   assign rsp_chan.cr_bits       = out_ctrl_ff.cr_bits;

endmodule

>>> hdl/ppcie_regfile.sv
// ----------------------------------------------------------------------------
// ppcie_regfile
// General register file: two registered read ports, one write port, per-entry
// valid bits for reset-to-zero and a bypass of the most recent write.
// ----------------------------------------------------------------------------
module ppcie_regfile #(
   parameter int REG_COUNT  = ppcie_pkg::REG_COUNT_DEF,
   parameter int DATA_WIDTH = ppcie_pkg::DATA_WIDTH_DEF,
   localparam int IDX_W     = $clog2(REG_COUNT)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr_a,
   input  logic [IDX_W-1:0]      rd_addr_b,
   output logic [DATA_WIDTH-1:0] rd_data_a,
   output logic [DATA_WIDTH-1:0] rd_data_b,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data
);

   logic [DATA_WIDTH-1:0] mem [REG_COUNT];

   logic [REG_COUNT-1:0]  vld_ff;
   logic [DATA_WIDTH-1:0] data_a_ff;
   logic [DATA_WIDTH-1:0] data_b_ff;
   logic                  vld_a_ff;
   logic                  vld_b_ff;
   logic [IDX_W-1:0]      addr_a_ff;
   logic [IDX_W-1:0]      addr_b_ff;
   logic                  byp_vld_ff;
   logic [IDX_W-1:0]      byp_addr_ff;
   logic [DATA_WIDTH-1:0] byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= mem[rd_addr_a];
         data_b_ff <= mem[rd_addr_b];
         vld_a_ff  <= vld_ff[rd_addr_a];
         vld_b_ff  <= vld_ff[rd_addr_b];
         addr_a_ff <= rd_addr_a;
         addr_b_ff <= rd_addr_b;
      end
      if (wr_en) begin
         byp_addr_ff <= wr_addr;
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         byp_vld_ff <= 1'b0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
         byp_vld_ff      <= 1'b1;
      end
   end

   // A write landing on the same edge as the read is missed by the array;
   // the bypass holds the newest write, which is also the current content.
   always_comb begin
      if (byp_vld_ff && byp_addr_ff == addr_a_ff) begin
         rd_data_a = byp_data_ff;
      end else if (vld_a_ff) begin
         rd_data_a = data_a_ff;
      end else begin
         rd_data_a = '0;
      end
      if (byp_vld_ff && byp_addr_ff == addr_b_ff) begin
         rd_data_b = byp_data_ff;
      end else if (vld_b_ff) begin
         rd_data_b = data_b_ff;
      end else begin
         rd_data_b = '0;
      end
   end

endmodule

>>> hdl/ppcie_alu.sv
// ----------------------------------------------------------------------------
// ppcie_alu
// Decode and execute of the D-form integer subset: arithmetic, logical,
// compare and record-form condition update.
// ----------------------------------------------------------------------------
module ppcie_alu #(
   parameter int DATA_WIDTH = ppcie_pkg::DATA_WIDTH_DEF
) (
   input  logic [ppcie_pkg::INSTR_WIDTH-1:0] instruction,
   input  logic [DATA_WIDTH-1:0]             opnd_a,
   input  logic [DATA_WIDTH-1:0]             opnd_s,
   output ppcie_pkg::ppcie_ctrl_type         ctrl,
   output logic [DATA_WIDTH-1:0]             result
);

   localparam int IMM_W = ppcie_pkg::IMM_WIDTH;
   localparam int HALF  = 32;

   logic [5:0]                        opcode;
   logic [ppcie_pkg::GPR_IDX_W-1:0]   rt;
   logic [ppcie_pkg::GPR_IDX_W-1:0]   ra;
   logic [ppcie_pkg::CR_FIELD_W-1:0]  bf;
   logic                              lbit;
   logic [IMM_W-1:0]                  imm;
   logic [DATA_WIDTH-1:0]             ui_ext;
   logic [DATA_WIDTH-1:0]             si_ext;
   logic [DATA_WIDTH-1:0]             ui_hi;
   logic [DATA_WIDTH-1:0]             si_hi;
   logic [DATA_WIDTH+IMM_W-1:0]       mul_wide;
   logic [DATA_WIDTH-1:0]             mul_fix;
   logic [DATA_WIDTH-1:0]             mul_lo;
   logic [DATA_WIDTH:0]               add_sum;
   logic [DATA_WIDTH:0]               sub_sum;
   logic [DATA_WIDTH-1:0]             base;
   logic [DATA_WIDTH-1:0]             cmp_x;
   logic [DATA_WIDTH-1:0]             cmp_y;
   logic [ppcie_pkg::CR_BITS_W-1:0]   cmp_bits;
   logic [ppcie_pkg::CR_BITS_W-1:0]   rec_bits;
   logic [DATA_WIDTH-1:0]             res;
   logic                              record;

   assign opcode = instruction[31:26];
   assign rt     = instruction[25:21];
   assign ra     = instruction[20:16];
   assign bf     = instruction[25:23];
   assign lbit   = instruction[21];
   assign imm    = instruction[15:0];

   assign ui_ext = {{(DATA_WIDTH-IMM_W){1'b0}}, imm};
   assign si_ext = {{(DATA_WIDTH-IMM_W){imm[IMM_W-1]}}, imm};
   assign ui_hi  = ui_ext << ppcie_pkg::IMM_SHIFT;
   assign si_hi  = si_ext << ppcie_pkg::IMM_SHIFT;

   // signed 16-bit multiplier as unsigned product minus a shifted correction
   assign mul_wide = opnd_a * imm;
   assign mul_fix  = imm[IMM_W-1] ? (opnd_a << IMM_W) : '0;
   assign mul_lo   = mul_wide[DATA_WIDTH-1:0] - mul_fix;

   assign add_sum = {1'b0, opnd_a} + {1'b0, si_ext};
   assign sub_sum = {1'b0, si_ext} + {1'b0, ~opnd_a} + (DATA_WIDTH+1)'(1);
   assign base    = (ra == '0) ? '0 : opnd_a;

   // compare operands, signed compare done by flipping the sign bits
   always_comb begin
      if (opcode == ppcie_pkg::OP_CMPI) begin
         cmp_x = lbit ? opnd_a
                      : {{(DATA_WIDTH-HALF){opnd_a[HALF-1]}}, opnd_a[HALF-1:0]};
         cmp_y = si_ext;
         cmp_x[DATA_WIDTH-1] = ~cmp_x[DATA_WIDTH-1];
         cmp_y[DATA_WIDTH-1] = ~cmp_y[DATA_WIDTH-1];
      end else begin
         cmp_x = lbit ? opnd_a : {{(DATA_WIDTH-HALF){1'b0}}, opnd_a[HALF-1:0]};
         cmp_y = ui_ext;
      end
      if (cmp_x < cmp_y) begin
         cmp_bits = ppcie_pkg::CR_LT;
      end else if (cmp_x > cmp_y) begin
         cmp_bits = ppcie_pkg::CR_GT;
      end else begin
         cmp_bits = ppcie_pkg::CR_EQ;
      end
   end

   always_comb begin
      ctrl   = '0;
      res    = '0;
      record = 1'b0;
      case (opcode)
         ppcie_pkg::OP_MULLI: begin
            res = mul_lo;
            ctrl.reg_written = 1'b1;
            ctrl.dest_index  = rt;
         end
         ppcie_pkg::OP_SUBFIC: begin
            res = sub_sum[DATA_WIDTH-1:0];
            ctrl.reg_written   = 1'b1;
            ctrl.dest_index    = rt;
            ctrl.carry_written = 1'b1;
            ctrl.carry_value   = sub_sum[DATA_WIDTH];
         end
         ppcie_pkg::OP_CMPLI, ppcie_pkg::OP_CMPI: begin
            ctrl.cr_written = 1'b1;
            ctrl.cr_field   = bf;
            ctrl.cr_bits    = cmp_bits;
         end
         ppcie_pkg::OP_ADDIC, ppcie_pkg::OP_ADDICR: begin
            res = add_sum[DATA_WIDTH-1:0];
            ctrl.reg_written   = 1'b1;
            ctrl.dest_index    = rt;
            ctrl.carry_written = 1'b1;
            ctrl.carry_value   = add_sum[DATA_WIDTH];
            record = (opcode == ppcie_pkg::OP_ADDICR);
         end
         ppcie_pkg::OP_ADDI: begin
            res = base + si_ext;
            ctrl.reg_written = 1'b1;
            ctrl.dest_index  = rt;
         end
         ppcie_pkg::OP_ADDIS: begin
            res = base + si_hi;
            ctrl.reg_written = 1'b1;
            ctrl.dest_index  = rt;
         end
         ppcie_pkg::OP_ORI: begin
            res = opnd_s | ui_ext;
            ctrl.reg_written = 1'b1;
            ctrl.dest_index  = ra;
         end
         ppcie_pkg::OP_ORIS: begin
            res = opnd_s | ui_hi;
            ctrl.reg_written = 1'b1;
            ctrl.dest_index  = ra;
         end
         ppcie_pkg::OP_XORI: begin
            res = opnd_s ^ ui_ext;
            ctrl.reg_written = 1'b1;
            ctrl.dest_index  = ra;
         end
         ppcie_pkg::OP_XORIS: begin
            res = opnd_s ^ ui_hi;
            ctrl.reg_written = 1'b1;
            ctrl.dest_index  = ra;
         end
         ppcie_pkg::OP_ANDIR: begin
            res = opnd_s & ui_ext;
            ctrl.reg_written = 1'b1;
            ctrl.dest_index  = ra;
            record = 1'b1;
         end
         ppcie_pkg::OP_ANDISR: begin
            res = opnd_s & ui_hi;
            ctrl.reg_written = 1'b1;
            ctrl.dest_index  = ra;
            record = 1'b1;
         end
         default: begin
            ctrl.status = ppcie_pkg::STATUS_UNIMPL;
         end
      endcase
      if (record) begin
         ctrl.cr_written = 1'b1;
         ctrl.cr_field   = '0;
         ctrl.cr_bits    = rec_bits;
      end
   end

   always_comb begin
      if (res[DATA_WIDTH-1]) begin
         rec_bits = ppcie_pkg::CR_LT;
      end else if (res == '0) begin
         rec_bits = ppcie_pkg::CR_EQ;
      end else begin
         rec_bits = ppcie_pkg::CR_GT;
      end
   end

   assign result = res;

endmodule
